// File: sv/acp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acp_pkg
// Types, constants and character helpers shared by the string to unsigned
// parser core and its per-character step logic.
// ----------------------------------------------------------------------------
package acp_pkg;

	localparam int VALUE_BITS = 32;
	localparam int BASE_BITS  = 6;
	localparam int POS_BITS   = 13;
	localparam int PROD_BITS  = VALUE_BITS + BASE_BITS + 1;
	localparam int CH_BITS    = 8;
	localparam int OUT_BITS   = VALUE_BITS + POS_BITS + 2;
	localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;
	localparam int OUT_TDATA  = OUT_BYTES * 8;

	localparam logic [POS_BITS-1:0]  MAX_CHARS  = POS_BITS'(4096);
	localparam logic [BASE_BITS-1:0] BASE_AUTO  = BASE_BITS'(0);
	localparam logic [BASE_BITS-1:0] BASE_MIN   = BASE_BITS'(2);
	localparam logic [BASE_BITS-1:0] BASE_MAX   = BASE_BITS'(36);
	localparam logic [BASE_BITS-1:0] BASE_OCT   = BASE_BITS'(8);
	localparam logic [BASE_BITS-1:0] BASE_DEC   = BASE_BITS'(10);
	localparam logic [BASE_BITS-1:0] BASE_HEX   = BASE_BITS'(16);
	localparam logic [BASE_BITS-1:0] BASE_NONE  = BASE_BITS'(0);
	localparam logic [BASE_BITS-1:0] NO_DIGIT   = '1;
	localparam logic [BASE_BITS-1:0] LETTER_OFS = BASE_BITS'(10);

	localparam logic [CH_BITS-1:0] CH_SPACE   = 8'h20;
	localparam logic [CH_BITS-1:0] CH_TAB     = 8'h09;
	localparam logic [CH_BITS-1:0] CH_CR      = 8'h0D;
	localparam logic [CH_BITS-1:0] CH_MINUS   = 8'h2D;
	localparam logic [CH_BITS-1:0] CH_PLUS    = 8'h2B;
	localparam logic [CH_BITS-1:0] CH_ZERO    = 8'h30;
	localparam logic [CH_BITS-1:0] CH_NINE    = 8'h39;
	localparam logic [CH_BITS-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CH_BITS-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CH_BITS-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CH_BITS-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [CH_BITS-1:0] CH_UPPER_X = 8'h58;
	localparam logic [CH_BITS-1:0] CH_LOWER_X = 8'h78;

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_SIGN,
		PH_ZERO,
		PH_PREFIX,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t                phase;
		logic [VALUE_BITS-1:0] acc;
		logic                  neg;
		logic                  ovf;
		logic                  dig;
		logic [BASE_BITS-1:0]  base;
		logic [POS_BITS-1:0]   pos;
		logic [POS_BITS-1:0]   stop;
	} parse_state_t;

	typedef struct packed {
		logic                  found_digits;
		logic                  overflowed;
		logic [POS_BITS-1:0]   stop_offset;
		logic [VALUE_BITS-1:0] value;
	} result_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_SPACE,
		acc:   '0,
		neg:   1'b0,
		ovf:   1'b0,
		dig:   1'b0,
		base:  BASE_DEC,
		pos:   '0,
		stop:  '0
	};

	// digit value of a character, NO_DIGIT for anything else
	function automatic logic [BASE_BITS-1:0] char_value(input logic [CH_BITS-1:0] c);
		logic [CH_BITS-1:0] t;
		t = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			t = c - CH_ZERO;
			return t[BASE_BITS-1:0];
		end
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			t = c - CH_LOWER_A;
			return t[BASE_BITS-1:0] + LETTER_OFS;
		end
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			t = c - CH_UPPER_A;
			return t[BASE_BITS-1:0] + LETTER_OFS;
		end
		return NO_DIGIT;
	endfunction

	function automatic logic [POS_BITS-1:0] next_pos(input logic [POS_BITS-1:0] p);
		return (p >= MAX_CHARS) ? MAX_CHARS : p + POS_BITS'(1);
	endfunction

endpackage

// File: sv/acp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acp_step
// Next parse state and result for one character: white space, sign, prefix
// detection and one multiply-add of the accumulator by the active base.
// ----------------------------------------------------------------------------
module acp_step (
	input  acp_pkg::parse_state_t            cur,
	input  logic [acp_pkg::CH_BITS-1:0]      ch,
	input  logic                             last,
	input  logic [acp_pkg::BASE_BITS-1:0]    number_base,
	output acp_pkg::parse_state_t            nxt,
	output acp_pkg::result_t                 res
);

	acp_pkg::parse_state_t            s;
	logic [acp_pkg::BASE_BITS-1:0]    d;
	logic                             take;
	logic                             first;
	logic [acp_pkg::PROD_BITS-1:0]    prod;
	logic [acp_pkg::POS_BITS-1:0]     npos;
	logic                             nb_auto_hex;

	assign npos        = acp_pkg::next_pos(cur.pos);
	assign nb_auto_hex = (number_base == acp_pkg::BASE_AUTO) ||
		(number_base == acp_pkg::BASE_HEX);

	always_comb begin
		s     = cur;
		take  = 1'b0;
		first = 1'b0;
		d     = acp_pkg::char_value(ch);
		prod  = '0;

		case (cur.phase)
			acp_pkg::PH_SPACE: begin
				if (ch == acp_pkg::CH_SPACE ||
					(ch >= acp_pkg::CH_TAB && ch <= acp_pkg::CH_CR)) begin
					s = cur;
				end else if (ch == acp_pkg::CH_MINUS) begin
					s.neg   = 1'b1;
					s.phase = acp_pkg::PH_SIGN;
				end else if (ch == acp_pkg::CH_PLUS) begin
					s.phase = acp_pkg::PH_SIGN;
				end else begin
					first = 1'b1;
				end
			end
			acp_pkg::PH_SIGN: begin
				first = 1'b1;
			end
			acp_pkg::PH_ZERO: begin
				if ((cur.base == acp_pkg::BASE_HEX || nb_auto_hex) &&
					(ch == acp_pkg::CH_LOWER_X || ch == acp_pkg::CH_UPPER_X)) begin
					s.base  = acp_pkg::BASE_HEX;
					s.phase = acp_pkg::PH_PREFIX;
				end else begin
					take = 1'b1;
				end
			end
			acp_pkg::PH_PREFIX, acp_pkg::PH_DIGITS: begin
				take = 1'b1;
			end
			default: begin
				s.phase = acp_pkg::PH_DONE;
			end
		endcase

		// first significant character samples the configured base
		if (first) begin
			if (nb_auto_hex && ch == acp_pkg::CH_ZERO) begin
				s.base  = (number_base == acp_pkg::BASE_AUTO) ? acp_pkg::BASE_OCT
					: acp_pkg::BASE_HEX;
				s.acc   = '0;
				s.dig   = 1'b1;
				s.stop  = npos;
				s.phase = acp_pkg::PH_ZERO;
			end else begin
				if (number_base == acp_pkg::BASE_AUTO) begin
					s.base = acp_pkg::BASE_DEC;
				end else if (number_base < acp_pkg::BASE_MIN ||
					number_base > acp_pkg::BASE_MAX) begin
					s.base = acp_pkg::BASE_NONE;
				end else begin
					s.base = number_base;
				end
				take = 1'b1;
			end
		end

		if (take) begin
			if (s.base < acp_pkg::BASE_MIN || d >= s.base) begin
				s.phase = acp_pkg::PH_DONE;
			end else begin
				prod = acp_pkg::PROD_BITS'(s.acc) * acp_pkg::PROD_BITS'(s.base)
					+ acp_pkg::PROD_BITS'(d);
				// any bit above the value width means the digit overflowed
				if (s.ovf || prod[acp_pkg::PROD_BITS-1:acp_pkg::VALUE_BITS] != '0) begin
					s.ovf = 1'b1;
				end else begin
					s.acc = prod[acp_pkg::VALUE_BITS-1:0];
				end
				s.dig   = 1'b1;
				s.stop  = npos;
				s.phase = acp_pkg::PH_DIGITS;
			end
		end

		s.pos = npos;

		res.found_digits = s.dig;
		res.overflowed   = s.ovf;
		res.stop_offset  = s.dig ? s.stop : '0;
		if (s.ovf) begin
			res.value = '1;
		end else if (s.neg) begin
			res.value = '0 - s.acc;
		end else begin
			res.value = s.acc;
		end

		nxt = last ? acp_pkg::STATE_RESET : s;
	end

endmodule

// File: sv/ascii_to_unsigned_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_to_unsigned_parser_core
// Streaming string to unsigned conversion, one character per word.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character per word in tdata[7:0]; tlast marks the
//   final character of a string. Only the word with tlast produces a result.
//   m_axis carries one result per string (fields listed at the port).
//   cfg_valid/cfg_data write the number base (0 = detect from prefix); it is
//   sampled at the first character after white space and sign. cfg_ready is
//   always high; write it only while no string word is in flight.
// Timing:
//   a character is registered in the input register at acceptance; the step
//   logic runs one multiply-add on it there and, for a last character, the
//   result register loads from it, which raises m_axis_tvalid.
//   One character per cycle is accepted while no last character waits for
//   the result register; the step is combinational, with a single result register.
// Reset:
//   arst_n clears the parse state, empties both registers and sets the base
//   to 10. When m_axis stalls, the held result stays; non-last characters keep
//   flowing, and a last character waits in the input register until the
//   result register frees up.
// ----------------------------------------------------------------------------
module ascii_to_unsigned_parser_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] ch
	input  logic                           s_axis_tlast,  // is_last
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [31:0] value, [44:32] stop_offset, [45] overflowed, [46] found_digits, [47] zero
	output logic [acp_pkg::OUT_TDATA-1:0]  m_axis_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [acp_pkg::BASE_BITS-1:0]  cfg_data
);

	logic                           valid_s1;
	logic [acp_pkg::CH_BITS-1:0]    ch_s1;
	logic                           last_s1;
	acp_pkg::parse_state_t          state_q;
	acp_pkg::parse_state_t          state_nxt;
	acp_pkg::result_t               res;
	acp_pkg::result_t               out_q;
	logic                           out_valid_q;
	logic [acp_pkg::BASE_BITS-1:0]  base_q;
	logic                           adv;

	// a non-last word never needs the result register
	assign adv           = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = acp_pkg::OUT_TDATA'(out_q);

	acp_step u_step (
		.cur         (state_q),
		.ch          (ch_s1),
		.last        (last_s1),
		.number_base (base_q),
		.nxt         (state_nxt),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= acp_pkg::BASE_DEC;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			ch_s1   <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acp_pkg::STATE_RESET;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_q <= res;
		end
	end

`ifndef SYNTHESIS
	// no digit means nothing else can be reported
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.found_digits |->
			out_q.value == '0 && out_q.stop_offset == '0 && !out_q.overflowed)
		else $error("result without digits carries data");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.overflowed |-> out_q.value == '1)
		else $error("overflowed result is not saturated");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> state_q.phase == acp_pkg::PH_SPACE && state_q.pos == '0)
		else $error("parse state not cleared after last character");

	assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.dig |-> state_q.stop == '0 && state_q.acc == '0)
		else $error("accumulator or stop position moved without a digit");
`endif

endmodule
